/* src/sng_pkg.sv */
// Shared types and constants of the stereo noise gate.
`timescale 1ns / 1ps
package sng_pkg;

    localparam int COEFF_BITS = 24;
    localparam int GAIN_BITS  = 32;
    localparam int THR_BITS   = 23;
    localparam int HOLD_BITS  = 17;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;
    localparam int ENV_EXTRA  = 16;

    localparam logic [GAIN_BITS-1:0] GAIN_ONE = 32'h8000_0000;
    localparam logic [GAIN_BITS-1:0] GAIN_HI  = 32'd2145336165;
    localparam logic [GAIN_BITS-1:0] GAIN_LO  = 32'd2147483;

    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ENV_ATTACK   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ENV_RELEASE  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_GATE_ATTACK  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_GATE_RELEASE = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD         = 3'd5;

    typedef enum logic [2:0] {
        PH_CLOSED  = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_OPEN    = 3'd2,
        PH_HOLD    = 3'd3,
        PH_RELEASE = 3'd4
    } sng_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DECIDE,
        ST_GSTART,
        ST_GMUL,
        ST_SEND
    } sng_state_t;

endpackage

/* src/sng_qmul.sv */
// Bit-serial unsigned multiply by a Q0.24 coefficient, floored.
`timescale 1ns / 1ps
module sng_qmul
    import sng_pkg::*;
#(
    parameter int DW = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DW-1:0]         d_in,
    input  logic [COEFF_BITS-1:0] c_in,
    output logic                  done,
    output logic [DW-1:0]         prod
);

    localparam int CW = $clog2(COEFF_BITS);
    localparam logic [CW-1:0] LAST = CW'(COEFF_BITS - 1);

    logic [DW-1:0]         acc_reg, d_reg;
    logic [COEFF_BITS-1:0] c_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg, done_reg;
    logic [DW:0]           sum;
    logic [DW-1:0]         acc_next;

    // one coefficient bit per cycle, drop one fraction bit per cycle
    always_comb begin
        sum      = {1'b0, acc_reg} + (c_reg[0] ? {1'b0, d_reg} : '0);
        acc_next = sum[DW:1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            d_reg   <= d_in;
            c_reg   <= c_in;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            c_reg   <= c_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

/* src/sng_gmul.sv */
// Bit-serial signed sample times Q1.31 gain, floored, two lanes.
`timescale 1ns / 1ps
module sng_gmul
    import sng_pkg::*;
#(
    parameter int SW = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [SW-1:0]        a_in,
    input  logic [SW-1:0]        b_in,
    input  logic [GAIN_BITS-1:0] g_in,
    output logic                 done,
    output logic [SW-1:0]        a_out,
    output logic [SW-1:0]        b_out
);

    localparam int CW = $clog2(GAIN_BITS);
    localparam logic [CW-1:0] LAST = CW'(GAIN_BITS - 2);

    logic [SW-1:0]        a_reg, b_reg, acc_a_reg, acc_b_reg;
    logic [GAIN_BITS-1:0] g_reg;
    logic                 top_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg, done_reg;
    logic [SW:0]          sum_a, sum_b;

    // fraction bits of the gain, arithmetic shift keeps the floor exact
    always_comb begin
        sum_a = {acc_a_reg[SW-1], acc_a_reg} + (g_reg[0] ? {a_reg[SW-1], a_reg} : '0);
        sum_b = {acc_b_reg[SW-1], acc_b_reg} + (g_reg[0] ? {b_reg[SW-1], b_reg} : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_a_reg <= '0;
            acc_b_reg <= '0;
            a_reg     <= a_in;
            b_reg     <= b_in;
            g_reg     <= g_in;
            top_reg   <= g_in[GAIN_BITS-1];
        end else if (busy_reg) begin
            acc_a_reg <= sum_a[SW:1];
            acc_b_reg <= sum_b[SW:1];
            g_reg     <= g_reg >> 1;
        end
    end

    // unity gain has no fraction bits set: pass the sample
    assign a_out = top_reg ? a_reg : acc_a_reg;
    assign b_out = top_reg ? b_reg : acc_b_reg;
    assign done  = done_reg;

endmodule

/* src/stereo_noise_gate.sv */
// Top level of the stereo noise gate with hold.
// Each item goes through prepare, the envelope and gain-ramp multiply steps, done,
//   decide, start, the output gain multiply steps, done and load; the bit-serial
//   multipliers work one coefficient or gain bit per cycle.
// One item at a time: the next item is taken only after the result is loaded,
//   later while the previous result still waits in the result register.
// Reset (aresetn low, synchronous): envelope and gain cleared, gate closed,
//   registers back to their defaults, no result pending.
`timescale 1ns / 1ps
module stereo_noise_gate
    import sng_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // input items
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,   // left_in, right_in
    // result items
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [((2*SAMPLE_BITS+10)/8)*8-1:0]  m_tdata,   // left_out, right_out,
                                                            // gate_phase
    // register writes
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int S     = SAMPLE_BITS;
    localparam int E     = S + ENV_EXTRA;
    localparam int OUT_W = ((2 * S + 3 + 7) / 8) * 8;

    localparam logic [S-1:0] MIN_NEG = {1'b1, {(S-1){1'b0}}};
    localparam logic [S-2:0] MAX_POS = {(S-1){1'b1}};

    // configuration registers
    logic [THR_BITS-1:0]   thr_reg;
    logic [COEFF_BITS-1:0] env_att_reg, env_rel_reg, gate_att_reg, gate_rel_reg;
    logic [HOLD_BITS-1:0]  hold_len_reg;

    // gate state
    sng_state_t            state_reg, state_next;
    sng_phase_t            phase_reg, phase_next;
    logic [E-1:0]          env_reg, env_next;
    logic [GAIN_BITS-1:0]  gain_reg, gain_next;
    logic [HOLD_BITS-1:0]  hcnt_reg, hcnt_next;

    // item in flight
    logic [S-1:0]          left_reg, right_reg;
    logic                  env_up_reg;

    // result register
    logic                  m_valid_reg, m_valid_next;
    logic [S-1:0]          lout_reg, rout_reg;
    logic [2:0]            pout_reg;
    logic                  load_out;

    // peak detect and multiplier operands
    logic [S-1:0]          neg_l, neg_r;
    logic [S-2:0]          mag_l, mag_r, peak;
    logic [E-1:0]          peak_e, env_d;
    logic [COEFF_BITS-1:0] env_c, gain_c;
    logic [GAIN_BITS-1:0]  gain_d;
    logic                  mul_start, env_done, gain_done, gmul_start, gmul_done;
    logic [E-1:0]          env_step;
    logic [GAIN_BITS-1:0]  gain_step;
    logic [S-1:0]          lg, rg;

    // decide stage
    logic [E-1:0]          thr_e, env_new;
    logic                  above, below;
    logic [GAIN_BITS-1:0]  g_up, g_dn;

    // take the register writes; unused indexes fall through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg      <= THR_BITS'(83886);
            env_att_reg  <= COEFF_BITS'(345943);
            env_rel_reg  <= COEFF_BITS'(34915);
            gate_att_reg <= COEFF_BITS'(345943);
            gate_rel_reg <= COEFF_BITS'(3495);
            hold_len_reg <= HOLD_BITS'(2400);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_THRESHOLD:    thr_reg      <= cfg_data[THR_BITS-1:0];
                REG_ENV_ATTACK:   env_att_reg  <= cfg_data[COEFF_BITS-1:0];
                REG_ENV_RELEASE:  env_rel_reg  <= cfg_data[COEFF_BITS-1:0];
                REG_GATE_ATTACK:  gate_att_reg <= cfg_data[COEFF_BITS-1:0];
                REG_GATE_RELEASE: gate_rel_reg <= cfg_data[COEFF_BITS-1:0];
                REG_HOLD:         hold_len_reg <= cfg_data[HOLD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // saturating magnitudes, larger one becomes the peak in envelope format
    always_comb begin
        neg_l  = -left_reg;
        neg_r  = -right_reg;
        mag_l  = !left_reg[S-1] ? left_reg[S-2:0] :
                 (left_reg == MIN_NEG) ? MAX_POS : neg_l[S-2:0];
        mag_r  = !right_reg[S-1] ? right_reg[S-2:0] :
                 (right_reg == MIN_NEG) ? MAX_POS : neg_r[S-2:0];
        peak   = (mag_l > mag_r) ? mag_l : mag_r;
        peak_e = {1'b0, peak, {ENV_EXTRA{1'b0}}};
        // step toward the peak, never past it
        env_d  = (peak_e > env_reg) ? (peak_e - env_reg) : (env_reg - peak_e);
        env_c  = (peak_e > env_reg) ? env_att_reg : env_rel_reg;
        // attack ramps toward unity, everything else decays
        gain_d = (phase_reg == PH_ATTACK) ? (GAIN_ONE - gain_reg) : gain_reg;
        gain_c = (phase_reg == PH_ATTACK) ? gate_att_reg : gate_rel_reg;
    end

    assign mul_start  = (state_reg == ST_PREP);
    assign gmul_start = (state_reg == ST_GSTART);

    sng_qmul #(.DW(E)) u_env_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .d_in    (env_d),
        .c_in    (env_c),
        .done    (env_done),
        .prod    (env_step)
    );

    sng_qmul #(.DW(GAIN_BITS)) u_gain_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .d_in    (gain_d),
        .c_in    (gain_c),
        .done    (gain_done),
        .prod    (gain_step)
    );

    sng_gmul #(.SW(S)) u_out_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gmul_start),
        .a_in    (left_reg),
        .b_in    (right_reg),
        .g_in    (gain_reg),
        .done    (gmul_done),
        .a_out   (lg),
        .b_out   (rg)
    );

    // envelope update and threshold compare
    always_comb begin
        env_new = env_up_reg ? (env_reg + env_step) : (env_reg - env_step);
        thr_e   = E'(thr_reg) << (S - 8);
        above   = env_new > thr_e;
        below   = env_new < thr_e;
        g_up    = gain_reg + gain_step;
        g_dn    = gain_reg - gain_step;
    end

    // sequencer and gate phase
    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        env_next     = env_reg;
        gain_next    = gain_reg;
        hcnt_next    = hcnt_reg;
        m_valid_next = m_valid_reg;
        load_out     = 1'b0;
        s_tready     = (state_reg == ST_IDLE);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (env_done && gain_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                env_next   = env_new;
                state_next = ST_GSTART;
                case (phase_reg)
                    PH_CLOSED: begin
                        gain_next = '0;
                        if (above) begin
                            phase_next = PH_ATTACK;
                        end
                    end
                    PH_ATTACK: begin
                        gain_next = g_up;
                        if (g_up >= GAIN_HI) begin
                            gain_next  = GAIN_ONE;
                            phase_next = PH_OPEN;
                            hcnt_next  = hold_len_reg;
                        end
                        // falling below wins over reaching open
                        if (below) begin
                            phase_next = PH_RELEASE;
                        end
                    end
                    PH_OPEN: begin
                        gain_next = GAIN_ONE;
                        if (below) begin
                            if (hold_len_reg != '0) begin
                                phase_next = PH_HOLD;
                                hcnt_next  = hold_len_reg;
                            end else begin
                                phase_next = PH_RELEASE;
                            end
                        end
                    end
                    PH_HOLD: begin
                        if (above) begin
                            phase_next = PH_OPEN;
                            hcnt_next  = hold_len_reg;
                        end else if (hcnt_reg <= HOLD_BITS'(1)) begin
                            hcnt_next  = '0;
                            phase_next = PH_RELEASE;
                        end else begin
                            hcnt_next = hcnt_reg - 1'b1;
                        end
                    end
                    default: begin
                        gain_next = g_dn;
                        if (g_dn <= GAIN_LO) begin
                            gain_next  = '0;
                            phase_next = PH_CLOSED;
                        end
                        // rising above wins over reaching closed
                        if (above) begin
                            phase_next = PH_ATTACK;
                        end
                    end
                endcase
            end
            ST_GSTART: begin
                state_next = ST_GMUL;
            end
            ST_GMUL: begin
                if (gmul_done) begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                // hold until the result slot is free
                if (!m_valid_reg || m_tready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_CLOSED;
            env_reg     <= '0;
            gain_reg    <= '0;
            hcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            env_reg     <= env_next;
            gain_reg    <= gain_next;
            hcnt_reg    <= hcnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // capture the item and the direction of the envelope step
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            left_reg  <= s_tdata[S-1:0];
            right_reg <= s_tdata[2*S-1:S];
        end
        if (state_reg == ST_PREP) begin
            env_up_reg <= (peak_e > env_reg);
        end
        if (load_out) begin
            lout_reg <= lg;
            rout_reg <= rg;
            pout_reg <= phase_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({pout_reg, rout_reg, lout_reg});

    a_closed_no_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_CLOSED) |-> (gain_reg == '0))
        else $error("gain not zero while closed");

    a_open_unity: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_OPEN || phase_reg == PH_HOLD) |-> (gain_reg == GAIN_ONE))
        else $error("gain not unity while open or holding");

    a_gain_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        gain_reg <= GAIN_ONE)
        else $error("gain above unity");

    a_env_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        env_reg <= {1'b0, MAX_POS, {ENV_EXTRA{1'b0}}})
        else $error("envelope above largest peak");

endmodule
